[hw/rtl/sky_face_bounds_accumulator_defines.svh]
// assertion macros shared by the checker of the face bounds accumulator
// depends on nothing; included by the checker file
`ifndef SKY_FACE_BOUNDS_ACCUMULATOR_DEFINES_SVH
`define SKY_FACE_BOUNDS_ACCUMULATOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sfb_pkg.sv]
// package of the face bounds accumulator: types, codes, widths, face table
// used by the control, datapath, divider and top modules of the block
`timescale 1ns / 1ps

package sfb_pkg;

    localparam int DirW     = 24;
    localparam int BoundW   = 16;
    localparam int FaceW    = 3;
    localparam int DefMaxVertices = 64;
    localparam int QuotW    = 40;   // (|num| << 14) fits 38 bits, plus margin

    localparam logic signed [BoundW-1:0] BoundMax = 16'sh7fff;
    localparam logic signed [BoundW-1:0] BoundMin = 16'sh8000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_VERTEX = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT,
        ST_RUN
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic store_vertex;  // write input vertex, add to sum
        logic set_overflow;
        logic clear_bounds;
        logic pick_face;     // latch chosen face from the sum
        logic set_read_face; // latch face_select for a read
        logic mem_read;      // read store entry at the index
        logic div_start;     // load the divider
        logic div_step;
        logic update;        // merge s/t into bounds
        logic index_inc;
        logic end_polygon;   // clear count, sum and overflow
        logic out_load;      // latch result register
        logic out_ovf_sel;   // result carries polygon overflow
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic store_full;
        logic index_done;    // index reached vertex count
        logic depth_ok;
        logic div_done;
    } t_status;

    // axis code: bit 2 negate, bits 1:0 component
    typedef logic [2:0] t_axis;

    function automatic t_axis face_axis(input logic [FaceW-1:0] f, input logic [1:0] k);
        t_axis a [6][3];
        a[0] = '{3'b101, 3'b010, 3'b000};
        a[1] = '{3'b001, 3'b010, 3'b100};
        a[2] = '{3'b000, 3'b010, 3'b001};
        a[3] = '{3'b100, 3'b010, 3'b101};
        a[4] = '{3'b101, 3'b100, 3'b010};
        a[5] = '{3'b101, 3'b000, 3'b110};
        if (f > 3'd5) begin
            return a[5][k];
        end
        return a[f][k];
    endfunction

endpackage

[hw/rtl/sfb_divider.sv]
// restoring divider, one quotient bit a cycle while i_step is high, two lanes for s and t
// depends on sfb_pkg
`timescale 1ns / 1ps

module sfb_divider
    import sfb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_step,
    input  logic signed [DirW:0]     i_num_s,
    input  logic signed [DirW:0]     i_num_t,
    input  logic        [DirW:0]     i_den,
    output logic                     o_done,
    output logic signed [BoundW-1:0] o_s,
    output logic signed [BoundW-1:0] o_t
);

    localparam int CntW = $clog2(QuotW + 1);

    logic [QuotW-1:0] r_qs, r_qt, n_qs, n_qt;
    logic [DirW:0]    r_rs, r_rt, n_rs, n_rt;
    logic [DirW:0]    r_den;
    logic             r_neg_s, r_neg_t;
    logic [CntW-1:0]  r_cnt;

    // one restoring step on one lane
    function automatic logic [DirW+QuotW:0] div_bit(input logic [DirW:0] rem,
        input logic [QuotW-1:0] q, input logic [DirW:0] den);
        logic [DirW+1:0] t;
        logic [DirW+1:0] d;
        logic [DirW+1:0] diff;
        t = {rem, q[QuotW-1]};
        d = {1'b0, den};
        diff = t - d;
        if (t >= d) begin
            return {diff[DirW:0], q[QuotW-2:0], 1'b1};
        end
        return {t[DirW:0], q[QuotW-2:0], 1'b0};
    endfunction

    always_comb begin
        {n_rs, n_qs} = div_bit(r_rs, r_qs, r_den);
        {n_rt, n_qt} = div_bit(r_rt, r_qt, r_den);
    end

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntW'(QuotW);
        end else if (i_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qs    <= {QuotW'(i_num_s < 0 ? -i_num_s : i_num_s)} << 14;
            r_qt    <= {QuotW'(i_num_t < 0 ? -i_num_t : i_num_t)} << 14;
            r_rs    <= '0;
            r_rt    <= '0;
            r_den   <= i_den;
            r_neg_s <= i_num_s < 0;
            r_neg_t <= i_num_t < 0;
        end else if (i_step && r_cnt != '0) begin
            r_qs <= n_qs;
            r_qt <= n_qt;
            r_rs <= n_rs;
            r_rt <= n_rt;
        end
    end

    assign o_done = (r_cnt == '0);

    // sign and saturate
    function automatic logic signed [BoundW-1:0] sat(input logic [QuotW-1:0] q,
        input logic neg);
        if (!neg) begin
            return (q > QuotW'(32767)) ? BoundMax : BoundW'(q);
        end
        return (q > QuotW'(32768)) ? BoundMin : BoundW'(-q);
    endfunction

    assign o_s = sat(r_qs, r_neg_s);
    assign o_t = sat(r_qt, r_neg_t);

endmodule

[hw/rtl/sfb_datapath.sv]
// datapath: vertex store, direction sums, face choice, bounds, result register
// depends on sfb_pkg and sfb_divider
`timescale 1ns / 1ps

module sfb_datapath
    import sfb_pkg::*;
#(
    parameter int MaxVertices = DefMaxVertices
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic signed [DirW-1:0]   i_dir_x,
    input  logic signed [DirW-1:0]   i_dir_y,
    input  logic signed [DirW-1:0]   i_dir_z,
    input  logic [FaceW-1:0]         i_face_select,
    output logic [FaceW-1:0]         o_face,
    output logic signed [BoundW-1:0] o_s_low,
    output logic signed [BoundW-1:0] o_t_low,
    output logic signed [BoundW-1:0] o_s_high,
    output logic signed [BoundW-1:0] o_t_high,
    output logic                     o_no_coverage,
    output logic                     o_vertex_overflow
);

    localparam int IdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
    localparam int CntW = $clog2(MaxVertices + 1);
    localparam int SumW = DirW + CntW;

    logic [3*DirW-1:0]       r_mem [MaxVertices];
    logic [3*DirW-1:0]       r_rd;
    logic [CntW-1:0]         r_count, r_idx;
    logic signed [SumW-1:0]  r_sum [3];
    logic                    r_ovf;
    logic [FaceW-1:0]        r_face;
    logic signed [BoundW-1:0] r_min [12];
    logic signed [BoundW-1:0] r_max [12];
    logic signed [DirW:0]    r_num_s, r_num_t, r_dep;

    logic                     div_done;
    logic signed [BoundW-1:0] q_s, q_t;

    // vertex store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_vertex) begin
            r_mem[r_count[IdxW-1:0]] <= {i_dir_z, i_dir_y, i_dir_x};
        end
        if (i_cmd.mem_read) begin
            r_rd <= r_mem[r_idx[IdxW-1:0]];
        end
    end

    // count, sum and overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.end_polygon) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end else begin
            if (i_cmd.store_vertex) begin
                r_count  <= r_count + 1'b1;
                r_sum[0] <= r_sum[0] + SumW'(i_dir_x);
                r_sum[1] <= r_sum[1] + SumW'(i_dir_y);
                r_sum[2] <= r_sum[2] + SumW'(i_dir_z);
            end
            if (i_cmd.set_overflow) r_ovf <= 1'b1;
        end
    end

    // face choice from the summed direction
    logic [SumW-1:0] ax, ay, az;
    logic [FaceW-1:0] n_face;
    always_comb begin
        ax = r_sum[0] < 0 ? SumW'(-r_sum[0]) : SumW'(r_sum[0]);
        ay = r_sum[1] < 0 ? SumW'(-r_sum[1]) : SumW'(r_sum[1]);
        az = r_sum[2] < 0 ? SumW'(-r_sum[2]) : SumW'(r_sum[2]);
        if (ax > ay && ax > az)      n_face = r_sum[0] < 0 ? 3'd1 : 3'd0;
        else if (ay > az && ay > ax) n_face = r_sum[1] < 0 ? 3'd3 : 3'd2;
        else                         n_face = r_sum[2] < 0 ? 3'd5 : 3'd4;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_face) r_face <= n_face;
        else if (i_cmd.set_read_face) r_face <= i_face_select > 3'd5 ? 3'd5 : i_face_select;
    end

    // vertex index walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.pick_face) r_idx <= '0;
        else if (i_cmd.index_inc)        r_idx <= r_idx + 1'b1;
    end

    // operand select for the chosen face
    function automatic logic signed [DirW:0] pick(input logic [3*DirW-1:0] v,
        input t_axis a);
        logic signed [DirW-1:0] c;
        case (a[1:0])
            2'd0:    c = v[DirW-1:0];
            2'd1:    c = v[2*DirW-1:DirW];
            default: c = v[3*DirW-1:2*DirW];
        endcase
        return a[2] ? -(DirW+1)'(c) : (DirW+1)'(c);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read == 1'b0 && i_cmd.div_start == 1'b0) begin
            r_num_s <= pick(r_rd, face_axis(r_face, 2'd0));
            r_num_t <= pick(r_rd, face_axis(r_face, 2'd1));
            r_dep   <= pick(r_rd, face_axis(r_face, 2'd2));
        end
    end

    sfb_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_step  (i_cmd.div_step),
        .i_num_s (r_num_s),
        .i_num_t (r_num_t),
        .i_den   (r_dep),
        .o_done  (div_done),
        .o_s     (q_s),
        .o_t     (q_t)
    );

    // bounds
    logic [3:0] si, ti;
    assign si = {r_face, 1'b0};
    assign ti = {r_face, 1'b1};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_bounds) begin
            for (int k = 0; k < 12; k++) begin
                r_min[k] <= BoundMax;
                r_max[k] <= BoundMin;
            end
        end else if (i_cmd.update) begin
            if (q_s < r_min[si]) r_min[si] <= q_s;
            if (q_t < r_min[ti]) r_min[ti] <= q_t;
            if (q_s > r_max[si]) r_max[si] <= q_s;
            if (q_t > r_max[ti]) r_max[ti] <= q_t;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_face            <= r_face;
            o_s_low           <= r_min[si];
            o_t_low           <= r_min[ti];
            o_s_high          <= r_max[si];
            o_t_high          <= r_max[ti];
            o_no_coverage     <= (r_min[si] >= r_max[si]) || (r_min[ti] >= r_max[ti]);
            o_vertex_overflow <= i_cmd.out_ovf_sel & r_ovf;
        end
    end

    assign o_status.store_full = (r_count == CntW'(MaxVertices));
    assign o_status.index_done = (r_idx == r_count);
    assign o_status.depth_ok   = (r_dep > 0);
    assign o_status.div_done   = div_done;

endmodule

[hw/rtl/sfb_control.sv]
// controller state machine of the face bounds accumulator
// depends on sfb_pkg
`timescale 1ns / 1ps

module sfb_control
    import sfb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_opcode i_opcode,
    input  logic    i_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state, n_state;
    logic   r_ovld, n_ovld;
    logic   r_ovf_sel, n_ovf_sel;
    logic   acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovld    <= 1'b0;
            r_ovf_sel <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ovld    <= n_ovld;
            r_ovf_sel <= n_ovf_sel;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE) && !r_ovld;
    assign o_out_valid = r_ovld;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_ovf_sel = r_ovf_sel;
        n_ovld    = r_ovld && !i_out_ready;
        o_cmd     = '0;
        o_cmd.out_ovf_sel = r_ovf_sel;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (i_opcode)
                        OP_CLEAR: o_cmd.clear_bounds = 1'b1;
                        OP_READ: begin
                            o_cmd.set_read_face = 1'b1;
                            n_ovf_sel = 1'b0;
                            n_state   = ST_EMIT;
                        end
                        OP_VERTEX: begin
                            o_cmd.store_vertex = !i_status.store_full;
                            o_cmd.set_overflow = i_status.store_full;
                            if (i_last) n_state = ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                // sum is final here
                o_cmd.pick_face = 1'b1;
                n_ovf_sel = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.index_done) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.mem_read  = 1'b1;
                    o_cmd.index_inc = 1'b1;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // operands registered this cycle
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.depth_ok) begin
                    n_state = ST_LOAD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_EMIT: begin
                o_cmd.out_load = 1'b1;
                if (r_ovf_sel) o_cmd.end_polygon = 1'b1;
                n_ovld  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RUN: begin
                // divider running
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_step = 1'b0;
                    o_cmd.update   = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/sky_face_bounds_accumulator.sv]
// Cube face bounds accumulator. Vertices (opcode vertex) are taken one per
// cycle while the block is idle and stored while the store has room; the
// last vertex starts a pass over the stored polygon in which each vertex
// with a depth above zero goes through the shared restoring divider,
// producing one quotient bit a cycle for s and t together; the others are
// skipped. Input is held off during the pass and while a result waits.
// Depends on sfb_pkg, sfb_control, sfb_datapath, sfb_divider.
`timescale 1ns / 1ps

module sky_face_bounds_accumulator
    import sfb_pkg::*;
#(
    parameter int MaxVertices = DefMaxVertices
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dir_x[23:0], dir_y[47:24], dir_z[71:48], face_select[74:72]
    input  logic [79:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // face[2:0], s_low[18:3], t_low[34:19], s_high[50:35], t_high[66:51],
    // no_coverage[67], vertex_overflow[68]
    output logic [71:0]  m_axis_tdata
);

    t_cmd    cmd;
    t_status st;
    logic [FaceW-1:0]         face;
    logic signed [BoundW-1:0] sl, tl, sh, th;
    logic                     nc, ov;

    sfb_control u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_opcode    (t_opcode'(s_axis_tuser)),
        .i_last      (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (st)
    );

    sfb_datapath #(.MaxVertices(MaxVertices)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (st),
        .i_dir_x           (s_axis_tdata[23:0]),
        .i_dir_y           (s_axis_tdata[47:24]),
        .i_dir_z           (s_axis_tdata[71:48]),
        .i_face_select     (s_axis_tdata[74:72]),
        .o_face            (face),
        .o_s_low           (sl),
        .o_t_low           (tl),
        .o_s_high          (sh),
        .o_t_high          (th),
        .o_no_coverage     (nc),
        .o_vertex_overflow (ov)
    );

    assign m_axis_tdata = {3'b000, ov, nc, th, sh, tl, sl, face};

endmodule

[hw/rtl/sfb_checker.sv]
// port-level checker of the face bounds accumulator, bound to the top level
// depends on the assertion macro header
`timescale 1ns / 1ps
`include "sky_face_bounds_accumulator_defines.svh"

module sfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    `SFB_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input taken while result waits")
    `SFB_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed")
    `SFB_ASSERT_IMPL(a_face_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd5, "face out of range")

endmodule

bind sky_face_bounds_accumulator sfb_checker u_sfb_checker (.*);
